// ----- sv/rhsl_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsl_pkg: shared constants and types for the RGB to HSL converter
// Channel and fraction widths, divider operand and result records.
// ----------------------------------------------------------------------------
package rhsl_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;

  // full-scale channel code, means 1.0
  localparam int FULL      = (2 ** CHANNEL_BITS) - 1;
  // operand / remainder width: covers 6*(max-min) and 2*FULL
  localparam int DIV_W     = CHANNEL_BITS + 3;
  // quotient width: one integer bit for a ratio of exactly 1.0
  localparam int QUOT_W    = FRACTION_BITS + 1;
  // one quotient bit per divider stage
  localparam int DIV_STAGES = QUOT_W;

  // lightness = sum * 2^(FRACTION_BITS-1) / FULL by reciprocal multiply;
  // a shift of 2*CHANNEL_BITS+1 keeps the product exact over 0..2*FULL
  localparam int              LIT_SHIFT   = 2 * CHANNEL_BITS + 1;
  localparam int              LIT_RECIP_W = CHANNEL_BITS + FRACTION_BITS + 1;
  localparam longint unsigned LIT_RECIP   =
      ((64'd1 << (LIT_SHIFT + FRACTION_BITS - 1)) + longint'(FULL) - 1) / longint'(FULL);

  localparam int IN_TDATA_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * FRACTION_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_op_t;

  typedef struct packed {
    div_op_t           hue;
    div_op_t           sat;
    // lightness quotient, already final; rides along with the divider
    logic [QUOT_W-1:0] lit;
    logic              gray;
  } div_req_t;

  typedef struct packed {
    logic [QUOT_W-1:0] hue;
    logic [QUOT_W-1:0] sat;
    logic [QUOT_W-1:0] lit;
    logic              gray;
  } div_res_t;

endpackage

// ----- sv/rgb_to_hsl_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter: streaming RGB to HSL pixel converter
// Hexcone HSL with six-sector hue, truncated unsigned fractions.
// ----------------------------------------------------------------------------
// One RGB pixel per item in, one HSL item out, in order. The block takes a
// new pixel every clock unless the output stalls; the path runs through an
// input register, a max/min stage, an operand stage, one stage per
// quotient bit in the restoring divider, and the output register. Each
// stage holds its item under backpressure, so stalls on the output lose
// and repeat nothing.
// Lightness is (max+min)/(2*full), done by a reciprocal multiply in the
// operand stage; saturation (max-min) over (max+min) or over
// (2*full-max-min) above one half, hue the six-sector value over six.
// Lightness and saturation of exactly 1.0 saturate to the top code; a hue
// of exactly 1.0 wraps to zero. For a gray pixel (max == min) hue and
// saturation are zero and the gray flag in m_axis_tuser is set.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // red, green, blue (CHANNEL_BITS each), zero padded
  input  logic [rhsl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hue, saturation, lightness (FRACTION_BITS each), zero padded
  output logic [rhsl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // gray
  output logic                                 m_axis_tuser
);

  localparam int CH = rhsl_pkg::CHANNEL_BITS;
  localparam int FB = rhsl_pkg::FRACTION_BITS;
  localparam int DW = rhsl_pkg::DIV_W;
  localparam int QW = rhsl_pkg::QUOT_W;
  localparam int RW = rhsl_pkg::LIT_RECIP_W;
  localparam int PW = CH + 1 + RW;

  localparam logic [DW-1:0] FULL_X = DW'(rhsl_pkg::FULL);
  localparam logic [DW-1:0] TWO_FULL_X = DW'(2 * rhsl_pkg::FULL);
  localparam logic [RW-1:0] LIT_RECIP_X = RW'(rhsl_pkg::LIT_RECIP);

  // ---------------- stage A: input register ----------------
  logic          a_v_q;
  logic [CH-1:0] a_r_q, a_g_q, a_b_q;
  logic          a_rdy;

  // ---------------- stage B: max / min ----------------
  logic          b_v_q;
  logic [CH-1:0] b_r_q, b_g_q, b_b_q, b_mx_q, b_mn_q;
  logic [CH-1:0] b_mx_d, b_mn_d;
  logic          b_rdy;

  // ---------------- stage C: divider operands ----------------
  logic               c_v_q;
  rhsl_pkg::div_req_t c_req_q, c_req_d;
  logic               c_rdy;

  // ---------------- divider and output ----------------
  logic               div_in_ready;
  logic               div_v;
  rhsl_pkg::div_res_t div_res;
  logic               f_rdy;
  logic               o_v_q;
  logic [FB-1:0]      o_hue_q, o_sat_q, o_lit_q, o_hue_d, o_sat_d, o_lit_d;
  logic               o_gray_q;

  // elastic ready chain: a stage loads when empty or its successor moves
  assign f_rdy = ~o_v_q | m_axis_tready;
  assign c_rdy = ~c_v_q | div_in_ready;
  assign b_rdy = ~b_v_q | c_rdy;
  assign a_rdy = ~a_v_q | b_rdy;
  assign s_axis_tready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= s_axis_tvalid;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (f_rdy) o_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && s_axis_tvalid) begin
      a_r_q <= s_axis_tdata[CH-1:0];
      a_g_q <= s_axis_tdata[2*CH-1:CH];
      a_b_q <= s_axis_tdata[3*CH-1:2*CH];
    end
  end

  // max / min of the three channels
  always_comb begin
    b_mx_d = a_r_q;
    b_mn_d = a_r_q;
    if (a_g_q > b_mx_d) b_mx_d = a_g_q;
    if (a_b_q > b_mx_d) b_mx_d = a_b_q;
    if (a_g_q < b_mn_d) b_mn_d = a_g_q;
    if (a_b_q < b_mn_d) b_mn_d = a_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      b_r_q  <= a_r_q;
      b_g_q  <= a_g_q;
      b_b_q  <= a_b_q;
      b_mx_q <= b_mx_d;
      b_mn_q <= b_mn_d;
    end
  end

  // operands: sector numerator over 6d, d over the lightness-dependent
  // denominator; lightness itself by reciprocal multiply
  always_comb begin
    logic [DW-1:0] mx_x, mn_x, r_x, g_x, b_x, d_x, sum_x, num;
    logic [PW-1:0] lit_prod;
    mx_x  = DW'(b_mx_q);
    mn_x  = DW'(b_mn_q);
    r_x   = DW'(b_r_q);
    g_x   = DW'(b_g_q);
    b_x   = DW'(b_b_q);
    d_x   = mx_x - mn_x;
    sum_x = mx_x + mn_x;

    priority if (b_r_q == b_mx_q) begin
      num = (b_g_q == b_mn_q) ? ((d_x << 2) + d_x + (mx_x - b_x)) : (d_x - (mx_x - g_x));
    end else if (b_g_q == b_mx_q) begin
      num = (b_b_q == b_mn_q) ? (d_x + (mx_x - r_x)) : ((d_x << 1) + d_x - (mx_x - b_x));
    end else begin
      num = (b_r_q == b_mn_q) ? ((d_x << 1) + d_x + (mx_x - g_x))
                              : ((d_x << 2) + d_x - (mx_x - r_x));
    end

    // sum * 2^(FB-1) / full, exact over 0..2*full; top bit set means 1.0
    lit_prod = PW'(sum_x[CH:0]) * PW'(LIT_RECIP_X);

    c_req_d.hue.num = num;
    c_req_d.hue.den = (d_x << 2) + (d_x << 1);
    c_req_d.sat.num = d_x;
    c_req_d.sat.den = (sum_x <= FULL_X) ? sum_x : (TWO_FULL_X - sum_x);
    c_req_d.lit     = lit_prod[rhsl_pkg::LIT_SHIFT +: QW];
    c_req_d.gray    = (b_mx_q == b_mn_q);
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy && b_v_q) begin
      c_req_q <= c_req_d;
    end
  end

  rhsl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_v_q),
    .in_ready_o  (div_in_ready),
    .in_req_i    (c_req_q),
    .out_valid_o (div_v),
    .out_ready_i (f_rdy),
    .out_res_o   (div_res)
  );

  // quotient bit FB set means exactly 1.0: hue wraps, others saturate;
  // gray forces hue and saturation to zero
  always_comb begin
    if (div_res.gray || div_res.hue[FB]) begin
      o_hue_d = '0;
    end else begin
      o_hue_d = div_res.hue[FB-1:0];
    end
    if (div_res.gray) begin
      o_sat_d = '0;
    end else if (div_res.sat[FB]) begin
      o_sat_d = '1;
    end else begin
      o_sat_d = div_res.sat[FB-1:0];
    end
    o_lit_d = div_res.lit[FB] ? '1 : div_res.lit[FB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && div_v) begin
      o_hue_q  <= o_hue_d;
      o_sat_q  <= o_sat_d;
      o_lit_q  <= o_lit_d;
      o_gray_q <= div_res.gray;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = rhsl_pkg::OUT_TDATA_W'({o_lit_q, o_sat_q, o_hue_q});
  assign m_axis_tuser  = o_gray_q;

endmodule

// ----- sv/rhsl_div.sv -----
// ----------------------------------------------------------------------------
// rhsl_div: two-lane pipelined restoring divider
// Gives floor(num * 2^FRACTION_BITS / den) for num <= den, one quotient bit
// per stage, with per-stage valid bits and an elastic ready chain. The
// lightness quotient travels alongside unchanged.
// ----------------------------------------------------------------------------
module rhsl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rhsl_pkg::div_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rhsl_pkg::div_res_t out_res_o
);

  localparam int DW = rhsl_pkg::DIV_W;
  localparam int QW = rhsl_pkg::QUOT_W;
  localparam int NS = rhsl_pkg::DIV_STAGES;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] q;
  } lane_t;

  typedef struct packed {
    lane_t         hue;
    lane_t         sat;
    logic [QW-1:0] lit;
    logic          gray;
  } stage_t;

  // one compare/subtract; the first stage does not shift (integer bit)
  function automatic lane_t step_lane(lane_t l, logic first);
    logic [DW:0] t;
    lane_t       o;
    t = first ? {1'b0, l.rem} : {l.rem, 1'b0};
    o = l;
    if (t >= {1'b0, l.den}) begin
      o.rem = DW'(t - {1'b0, l.den});
      o.q   = {l.q[QW-2:0], 1'b1};
    end else begin
      o.rem = t[DW-1:0];
      o.q   = {l.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic stage_t step_stage(stage_t s, logic first);
    stage_t o;
    o      = s;
    o.hue  = step_lane(s.hue, first);
    o.sat  = step_lane(s.sat, first);
    return o;
  endfunction

  stage_t          st_in [NS];
  stage_t          st_d  [NS];
  stage_t          st_q  [NS];
  logic [NS-1:0]   v_in;
  logic [NS-1:0]   v_q;
  logic [NS:0]     rdy;

  assign rdy[NS]    = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign v_in[k]           = in_valid_i;
      assign st_in[k].hue.rem  = in_req_i.hue.num;
      assign st_in[k].hue.den  = in_req_i.hue.den;
      assign st_in[k].hue.q    = '0;
      assign st_in[k].sat.rem  = in_req_i.sat.num;
      assign st_in[k].sat.den  = in_req_i.sat.den;
      assign st_in[k].sat.q    = '0;
      assign st_in[k].lit      = in_req_i.lit;
      assign st_in[k].gray     = in_req_i.gray;
    end else begin : g_next
      assign v_in[k]  = v_q[k-1];
      assign st_in[k] = st_q[k-1];
    end

    assign st_d[k] = step_stage(st_in[k], (k == 0));
    assign rdy[k]  = ~v_q[k] | rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o    = v_q[NS-1];
  assign out_res_o.hue  = st_q[NS-1].hue.q;
  assign out_res_o.sat  = st_q[NS-1].sat.q;
  assign out_res_o.lit  = st_q[NS-1].lit;
  assign out_res_o.gray = st_q[NS-1].gray;

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the streaming RGB to HSL converter
// Drives RGB pixels with random gaps and output stalls, predicts each HSL
// item from exact integer arithmetic, and checks items in order.
// ----------------------------------------------------------------------------
// Flow: directed corner pixels, a large mixed random run, back-to-back
// traffic, a long output hold-off that fills the pipeline, and a pause that
// drains the block before more traffic. Each accepted input is turned into
// an expected HSL item in the scoreboard, and every output item is checked
// against the oldest pending one.
// ----------------------------------------------------------------------------
module tb;

  localparam int              CHANNEL_BITS  = rhsl_pkg::CHANNEL_BITS;
  localparam int              FRACTION_BITS = rhsl_pkg::FRACTION_BITS;
  localparam int              FULL          = rhsl_pkg::FULL;
  localparam int              IN_TDATA_W    = rhsl_pkg::IN_TDATA_W;
  localparam int              OUT_TDATA_W   = rhsl_pkg::OUT_TDATA_W;
  localparam int              LATENCY     = rhsl_pkg::DIV_STAGES + 4;
  localparam int              DRAIN_TAIL  = 2 * LATENCY;
  localparam int              LONG_HOLD   = 300;
  localparam int              CYCLE_LIMIT = 600000;
  localparam int              PRINT_LIMIT = 40;
  localparam longint unsigned FRAC_ONE    = 64'd1 << FRACTION_BITS;
  localparam longint unsigned FRAC_TOP    = FRAC_ONE - 1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] sat;
    logic [FRACTION_BITS-1:0] lit;
    logic                     gray;
  } hsl_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // expected HSL items, oldest first
  hsl_t hsl_expected_q[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;

  // traffic shaping, written by the test sequence at rising edges
  logic gaps_on   = 1'b1;
  int   hold_req  = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  rgb_to_hsl_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // floor(num * 2^FRACTION_BITS / den), clipped at the top code
  function automatic logic [FRACTION_BITS-1:0] ratio_trunc(input longint unsigned num,
                                                          input longint unsigned den);
    longint unsigned q;
    q = (num << FRACTION_BITS) / den;
    if (q > FRAC_TOP) q = FRAC_TOP;
    return q[FRACTION_BITS-1:0];
  endfunction

  function automatic hsl_t hsl_of_rgb(input rgb_t px);
    longint unsigned r, g, b, full, hi, lo, d, sum, num, q;
    hsl_t res;
    r    = 64'(px.red);
    g    = 64'(px.green);
    b    = 64'(px.blue);
    full = 64'(FULL);
    hi   = r;
    lo   = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sum      = hi + lo;
    d        = hi - lo;
    res.lit  = ratio_trunc(sum, 2 * full);
    res.gray = (d == 0);
    res.hue  = '0;
    res.sat  = '0;
    if (d != 0) begin
      // above one half the denominator is the distance from white
      if (sum <= full) res.sat = ratio_trunc(d, sum);
      else res.sat = ratio_trunc(d, 2 * full - sum);
      // six-sector numerator of 6*hue over d; sector order matters on ties
      if (r == hi) num = (g == lo) ? 5 * d + (hi - b) : d - (hi - g);
      else if (g == hi) num = (b == lo) ? d + (hi - r) : 3 * d - (hi - b);
      else num = (r == lo) ? 3 * d + (hi - g) : 5 * d - (hi - r);
      q = (num << FRACTION_BITS) / (6 * d);
      // a full turn wraps back to zero
      res.hue = (q >= FRAC_ONE) ? '0 : q[FRACTION_BITS-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
               cycle_count);
    mismatch_count++;
  endtask

  // output check first, then the expectation for a pixel taken at this edge
  always @(posedge clk_i) begin : scoreboard
    hsl_t got, want;
    rgb_t px;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hue  = m_axis_tdata[FRACTION_BITS-1:0];
        got.sat  = m_axis_tdata[2*FRACTION_BITS-1:FRACTION_BITS];
        got.lit  = m_axis_tdata[3*FRACTION_BITS-1:2*FRACTION_BITS];
        got.gray = m_axis_tuser;
        if (hsl_expected_q.size() == 0) begin
          report_mismatch("item with none pending", 64'(m_axis_tdata), 64'd0);
        end else begin
          want = hsl_expected_q.pop_front();
          if (got.hue != want.hue)
            report_mismatch("hue", 64'(got.hue), 64'(want.hue));
          if (got.sat != want.sat)
            report_mismatch("saturation", 64'(got.sat), 64'(want.sat));
          if (got.lit != want.lit)
            report_mismatch("lightness", 64'(got.lit), 64'(want.lit));
          if (got.gray != want.gray)
            report_mismatch("gray", 64'(got.gray), 64'(want.gray));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        px.red   = s_axis_tdata[CHANNEL_BITS-1:0];
        px.green = s_axis_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
        px.blue  = s_axis_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
        hsl_expected_q.push_back(hsl_of_rgb(px));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : receiver
    int roll;
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!gaps_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        m_axis_tready <= 1'b1;
      end else if (roll < 92) begin
        stall_left    <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        stall_left    <= $urandom_range(8, 40);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called right after a rising edge; returns on the edge that takes the item
  task automatic send_pixel(input rgb_t px);
    int gap;
    logic [IN_TDATA_W-1:0] word;
    gap  = pick_gap();
    word = '0;
    word[3*CHANNEL_BITS-1:0] = {px.blue, px.green, px.red};
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    rgb_t px;
    px.red   = r[CHANNEL_BITS-1:0];
    px.green = g[CHANNEL_BITS-1:0];
    px.blue  = b[CHANNEL_BITS-1:0];
    send_pixel(px);
  endtask

  // stop offering and wait until every expected item is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (hsl_expected_q.size() != 0);
  endtask

  function automatic logic [CHANNEL_BITS-1:0] jitter(input int v);
    int x;
    x = v + $urandom_range(0, 6) - 3;
    if (x < 0) x = 0;
    if (x > FULL) x = FULL;
    return x[CHANNEL_BITS-1:0];
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] extreme_channel();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return FULL[CHANNEL_BITS-1:0];
      default: return CHANNEL_BITS'($urandom_range(0, FULL));
    endcase
  endfunction

  // mix of uniform, gray, saturated, near-gray and tied pixels
  function automatic rgb_t random_pixel();
    rgb_t px;
    int roll, v, w;
    roll = $urandom_range(0, 99);
    v    = $urandom_range(0, FULL);
    w    = $urandom_range(0, FULL);
    if (roll < 45) begin
      px.red   = CHANNEL_BITS'($urandom_range(0, FULL));
      px.green = CHANNEL_BITS'($urandom_range(0, FULL));
      px.blue  = CHANNEL_BITS'($urandom_range(0, FULL));
    end else if (roll < 55) begin
      px = {3{v[CHANNEL_BITS-1:0]}};
    end else if (roll < 70) begin
      px.red   = extreme_channel();
      px.green = extreme_channel();
      px.blue  = extreme_channel();
    end else if (roll < 85) begin
      px.red   = jitter(v);
      px.green = jitter(v);
      px.blue  = jitter(v);
    end else begin
      // two channels tie, which exercises the sector priority
      case ($urandom_range(0, 2))
        0:       px = {v[CHANNEL_BITS-1:0], v[CHANNEL_BITS-1:0], w[CHANNEL_BITS-1:0]};
        1:       px = {v[CHANNEL_BITS-1:0], w[CHANNEL_BITS-1:0], v[CHANNEL_BITS-1:0]};
        default: px = {w[CHANNEL_BITS-1:0], v[CHANNEL_BITS-1:0], v[CHANNEL_BITS-1:0]};
      endcase
    end
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // gray levels, primaries, secondaries, all six sectors, the one-half
  // boundary of saturation, saturation/lightness of one, hue wrap
  task automatic test_directed();
    int mid;
    mid = (FULL + 1) / 2;
    gaps_on <= 1'b1;
    send_rgb(0, 0, 0);                    // black
    send_rgb(FULL, FULL, FULL);           // white, lightness clips
    send_rgb(mid, mid, mid);              // mid gray
    send_rgb(FULL, 0, 0);                 // red: hue of one wraps, sat clips
    send_rgb(0, FULL, 0);
    send_rgb(0, 0, FULL);
    send_rgb(FULL, FULL, 0);              // yellow, red wins the tie
    send_rgb(0, FULL, FULL);              // cyan, green wins the tie
    send_rgb(FULL, 0, FULL);              // magenta, red wins the tie
    send_rgb(FULL, 0, 1);                 // just below a full turn
    send_rgb(FULL, 1, 0);
    send_rgb(1, 0, 0);                    // smallest spread, sat clips
    send_rgb(FULL, FULL, FULL - 1);       // near white
    send_rgb(200, 100, 50);               // six sectors
    send_rgb(200, 50, 100);
    send_rgb(100, 200, 50);
    send_rgb(50, 200, 100);
    send_rgb(50, 100, 200);
    send_rgb(100, 50, 200);
    send_rgb(mid - 1, mid, mid);          // max+min exactly full scale
    send_rgb(mid, mid, mid - 1);
    send_rgb(mid, mid + 1, mid);          // just above one half
    send_rgb(0, FULL, 1);
    send_rgb(1, FULL, 0);
    send_rgb(FULL - 1, FULL, FULL);
  endtask

  task automatic test_random_mix();
    gaps_on <= 1'b1;
    repeat (1000) send_pixel(random_pixel());
  endtask

  // back-to-back items with the receiver always ready
  task automatic test_back_to_back();
    gaps_on <= 1'b0;
    repeat (150) send_pixel(random_pixel());
  endtask

  // receiver holds off while the sender keeps offering: the pipeline fills
  // and the input side must stall without dropping or repeating items
  task automatic test_long_backpressure();
    gaps_on  <= 1'b0;
    hold_req <= hold_req + 1;
    repeat (100) send_pixel(random_pixel());
  endtask

  // sender pauses until the block is empty, then resumes
  task automatic test_drain_pause();
    gaps_on <= 1'b1;
    repeat (40) send_pixel(random_pixel());
    drain();
    repeat (40) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix();
    test_back_to_back();
    test_long_backpressure();
    test_drain_pause();
    drain();
    // catch stray items after the last expected one
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
